// ===== rtl/core/vtbr_pkg.sv =====
// ----------------------------------------------------------------------------
// vtbr_pkg: shared types and constants for the vertex transform block
// Register map, configuration bundle, root cell data and lane helper.
// ----------------------------------------------------------------------------
package vtbr_pkg;

  // default vertex coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // coefficient and center lanes are always 16 bits
  localparam int unsigned LANE_W = 16;

  // root result and its clamp value
  localparam int unsigned RADIUS_W = 17;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

  // integer square root over a 64-bit radicand: one result bit per cell
  localparam int unsigned SUMSQ_W    = 64;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned ROOT_MSB   = 62;

  // magnitudes at or above this bit force the radius to its clamp
  localparam int unsigned MAG_W = 31;

  // configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CENTER_W   = 48;

  typedef enum logic [1:0] {
    REG_ROW_X  = 2'd0,
    REG_ROW_Y  = 2'd1,
    REG_ROW_Z  = 2'd2,
    REG_CENTER = 2'd3
  } reg_idx_e;

  localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW_Z_RST = 64'h0000_0100_0000_0000;
  localparam logic [CENTER_W-1:0] CENTER_RST = '0;

  // configuration seen by the transform stages
  typedef struct packed {
    logic [63:0]         row_x;
    logic [63:0]         row_y;
    logic [63:0]         row_z;
    logic [CENTER_W-1:0] center;
  } cfg_t;

  // word handed from one root cell to the next
  typedef struct packed {
    logic [SUMSQ_W-1:0] rem;
    logic [SUMSQ_W-1:0] root;
    logic               big;
  } root_t;

  // signed 16-bit lane k of a packed register
  function automatic logic signed [LANE_W-1:0] lane(input logic [63:0] r,
                                                    input int unsigned k);
    return signed'(r[LANE_W*k +: LANE_W]);
  endfunction

endpackage

// ===== rtl/core/vtbr_xform.sv =====
// ----------------------------------------------------------------------------
// vtbr_xform: affine transform and squared distance front end
// Seven registered stages: capture, products, row sums, floor and saturate,
// center difference, squares, sum of squares.
// ----------------------------------------------------------------------------
module vtbr_xform #(
  parameter int unsigned COORD_WIDTH = vtbr_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vtbr_pkg::cfg_t         cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [COORD_WIDTH-1:0] vx_i,
  input  logic [COORD_WIDTH-1:0] vy_i,
  input  logic [COORD_WIDTH-1:0] vz_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output vtbr_pkg::root_t        root_o,
  output logic [3*COORD_WIDTH-1:0] coord_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned LW     = vtbr_pkg::LANE_W;
  localparam int unsigned PRW    = W + LW;
  localparam int unsigned SW     = W + LW + 2;
  localparam int unsigned FW     = SW - 8;
  localparam int unsigned DW     = ((W > LW) ? W : LW) + 1;
  localparam int unsigned MW     = vtbr_pkg::MAG_W;
  localparam int unsigned SQW    = 2 * MW;
  localparam int unsigned NSTAGE = 7;

  localparam logic signed [FW-1:0] SAT_HI = {{(FW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [FW-1:0] SAT_LO = {{(FW-W+1){1'b1}}, {(W-1){1'b0}}};

  // stage handshake
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE:0]   rdy;

  // stage registers
  logic signed [W-1:0]   v_q   [3];
  logic signed [PRW-1:0] p_q   [3][3];
  logic signed [LW-1:0]  t_q   [3];
  logic signed [SW-1:0]  sum_q [3];
  logic signed [W-1:0]   o3_q  [3];
  logic signed [W-1:0]   o4_q  [3];
  logic signed [W-1:0]   o5_q  [3];
  logic signed [W-1:0]   o6_q  [3];
  logic [MW-1:0]         mag_q [3];
  logic                  big4_q;
  logic                  big5_q;
  logic                  big6_q;
  logic [SQW-1:0]        sq_q  [3];
  logic [vtbr_pkg::SUMSQ_W-1:0] n_q;

  // combinational helpers
  logic [63:0]           row [3];
  logic signed [LW-1:0]  ctr [3];
  logic signed [PRW-1:0] p_d [3][3];
  logic signed [SW-1:0]  sum_d [3];
  logic signed [FW-1:0]  fl [3];
  logic signed [W-1:0]   o3_d [3];
  logic signed [DW-1:0]  dif [3];
  logic [DW-1:0]         mag [3];
  logic [63:0]           mag64 [3];
  logic [MW-1:0]         mag_d [3];
  logic                  big_d;

  assign row[0] = cfg_i.row_x;
  assign row[1] = cfg_i.row_y;
  assign row[2] = cfg_i.row_z;

  // a stage takes a word when it is empty or its word moves on
  always_comb begin
    rdy[NSTAGE] = ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // products and row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_d[r][c] = PRW'(vtbr_pkg::lane(row[r], c)) * PRW'(v_q[c]);
      end
      sum_d[r] = SW'(p_q[r][0]) + SW'(p_q[r][1]) + SW'(p_q[r][2])
               + (SW'(t_q[r]) <<< 8);
    end
  end

  // floor to q8.8 and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      fl[r] = sum_q[r][SW-1:8];
      if (fl[r] > SAT_HI) begin
        o3_d[r] = SAT_HI[W-1:0];
      end else if (fl[r] < SAT_LO) begin
        o3_d[r] = SAT_LO[W-1:0];
      end else begin
        o3_d[r] = fl[r][W-1:0];
      end
    end
  end

  // distance components to the center
  assign ctr[0] = vtbr_pkg::lane(64'(cfg_i.center), 0);
  assign ctr[1] = vtbr_pkg::lane(64'(cfg_i.center), 1);
  assign ctr[2] = vtbr_pkg::lane(64'(cfg_i.center), 2);

  always_comb begin
    big_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      dif[r]   = DW'(o3_q[r]) - DW'(ctr[r]);
      mag[r]   = dif[r][DW-1] ? DW'(-dif[r]) : DW'(dif[r]);
      mag64[r] = 64'(mag[r]);
      mag_d[r] = mag64[r][MW-1:0];
      big_d    = big_d || (mag64[r][63:MW] != '0);
    end
  end

  // stage data registers
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      v_q[0] <= signed'(vx_i);
      v_q[1] <= signed'(vy_i);
      v_q[2] <= signed'(vz_i);
    end
    if (rdy[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= p_d[r][c];
        end
        t_q[r] <= vtbr_pkg::lane(row[r], 3);
      end
    end
    if (rdy[2]) begin
      for (int r = 0; r < 3; r++) sum_q[r] <= sum_d[r];
    end
    if (rdy[3]) begin
      for (int r = 0; r < 3; r++) o3_q[r] <= o3_d[r];
    end
    if (rdy[4]) begin
      for (int r = 0; r < 3; r++) begin
        o4_q[r]  <= o3_q[r];
        mag_q[r] <= mag_d[r];
      end
      big4_q <= big_d;
    end
    if (rdy[5]) begin
      for (int r = 0; r < 3; r++) begin
        o5_q[r] <= o4_q[r];
        sq_q[r] <= SQW'(mag_q[r]) * SQW'(mag_q[r]);
      end
      big5_q <= big4_q;
    end
    if (rdy[6]) begin
      for (int r = 0; r < 3; r++) o6_q[r] <= o5_q[r];
      n_q    <= vtbr_pkg::SUMSQ_W'(sq_q[0]) + vtbr_pkg::SUMSQ_W'(sq_q[1])
              + vtbr_pkg::SUMSQ_W'(sq_q[2]);
      big6_q <= big5_q;
    end
  end

  assign ready_o     = rdy[0];
  assign valid_o     = vld_q[NSTAGE-1];
  assign root_o.rem  = n_q;
  assign root_o.root = '0;
  assign root_o.big  = big6_q;
  assign coord_o     = {o6_q[2], o6_q[1], o6_q[0]};

endmodule

// ===== rtl/core/vtbr_root_cell.sv =====
// ----------------------------------------------------------------------------
// vtbr_root_cell: one step of the integer square root chain
// Tries one result bit against the running remainder and hands the word on.
// ----------------------------------------------------------------------------
module vtbr_root_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned PW   = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  vtbr_pkg::root_t root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  input  logic            ready_i,
  output vtbr_pkg::root_t root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int unsigned NW = vtbr_pkg::SUMSQ_W;
  localparam logic [NW-1:0] BIT = NW'(1) << (vtbr_pkg::ROOT_MSB - 2 * STEP);

  logic            valid_q;
  vtbr_pkg::root_t root_q;
  vtbr_pkg::root_t root_d;
  logic [PW-1:0]   pay_q;
  logic [NW-1:0]   trial;

  assign ready_o = !valid_q || ready_i;

  // trial subtract of this bit
  always_comb begin
    trial      = root_i.root + BIT;
    root_d.big = root_i.big;
    if (root_i.rem >= trial) begin
      root_d.rem  = root_i.rem - trial;
      root_d.root = (root_i.root >> 1) + BIT;
    end else begin
      root_d.rem  = root_i.rem;
      root_d.root = root_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ===== rtl/core/vtbr_out.sv =====
// ----------------------------------------------------------------------------
// vtbr_out: radius clamp, running maximum and output register
// Holds the finished word until the receiver takes it.
// ----------------------------------------------------------------------------
module vtbr_out #(
  parameter int unsigned PW = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  vtbr_pkg::root_t               root_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [PW-1:0]                 pay_o,
  output logic [vtbr_pkg::RADIUS_W-1:0] radius_o
);

  localparam int unsigned RW = vtbr_pkg::RADIUS_W;

  logic          valid_q;
  logic [RW-1:0] max_q;
  logic [RW-1:0] max_d;
  logic [RW-1:0] rad;
  logic [PW-1:0] pay_q;
  logic          load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // clamp the root, then keep the larger radius
  always_comb begin
    if (root_i.big || (root_i.root[vtbr_pkg::SUMSQ_W-1:RW] != '0)) begin
      rad = vtbr_pkg::RADIUS_MAX;
    end else begin
      rad = root_i.root[RW-1:0];
    end
    max_d = (rad > max_q) ? rad : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      max_q   <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pay_q <= pay_i;
    end
  end

  assign valid_o  = valid_q;
  assign pay_o    = pay_q;
  assign radius_o = max_q;

endmodule

// ===== rtl/core/vertex_transform_bounding_radius.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_bounding_radius: affine vertex transform with radius
// Transforms q8.8 vertices by three matrix rows and tracks the largest
// distance from a configured center.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vertex per word, tdata = {z, y, x} from the low bits.
//   m_axis returns one word per vertex, in order, tdata = {radius, z, y, x}
//   with radius the running maximum distance including this vertex.
//   The apb port writes the three rows (0x00, 0x08, 0x10) and the center
//   (0x18); write it only while no vertex is in flight.
// Pipeline:
//   from acceptance to m_axis_tvalid a vertex passes seven transform
//   and distance stages, 32 square root cells (one root bit per cell) and
//   the output register. A new vertex is taken every cycle while there is room.
// Reset:
//   clears all stages, the running maximum and restores the identity rows
//   and a zero center.
// Stall:
//   when m_axis_tready is low the output word holds; earlier stages keep
//   filling until every cell is occupied, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module vertex_transform_bounding_radius #(
  parameter int unsigned COORD_WIDTH = vtbr_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  // vertex words
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0: vertex_x, vertex_y, vertex_z
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,

  // result words
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // fields from bit 0: out_x, out_y, out_z, radius
  output logic [((3*COORD_WIDTH+vtbr_pkg::RADIUS_W+7)/8)*8-1:0] m_axis_tdata,

  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vtbr_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [vtbr_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [vtbr_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned PW    = 3 * W;
  localparam int unsigned NCELL = vtbr_pkg::ROOT_STEPS;
  localparam int unsigned ODW   = ((3 * W + vtbr_pkg::RADIUS_W + 7) / 8) * 8;

  vtbr_pkg::cfg_t     cfg_q;
  vtbr_pkg::reg_idx_e idx;
  logic               wr_en;

  // root chain links
  logic            c_vld [NCELL+1];
  logic            c_rdy [NCELL+1];
  vtbr_pkg::root_t c_dat [NCELL+1];
  logic [PW-1:0]   c_pay [NCELL+1];

  logic                          out_rdy;
  logic [PW-1:0]                 out_pay;
  logic [vtbr_pkg::RADIUS_W-1:0] out_rad;

  // register write
  assign pready = 1'b1;
  assign idx    = vtbr_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x  <= vtbr_pkg::ROW_X_RST;
      cfg_q.row_y  <= vtbr_pkg::ROW_Y_RST;
      cfg_q.row_z  <= vtbr_pkg::ROW_Z_RST;
      cfg_q.center <= vtbr_pkg::CENTER_RST;
    end else if (wr_en) begin
      case (idx)
        vtbr_pkg::REG_ROW_X:  cfg_q.row_x  <= pwdata;
        vtbr_pkg::REG_ROW_Y:  cfg_q.row_y  <= pwdata;
        vtbr_pkg::REG_ROW_Z:  cfg_q.row_z  <= pwdata;
        vtbr_pkg::REG_CENTER: cfg_q.center <= pwdata[vtbr_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (idx)
      vtbr_pkg::REG_ROW_X:  prdata = cfg_q.row_x;
      vtbr_pkg::REG_ROW_Y:  prdata = cfg_q.row_y;
      vtbr_pkg::REG_ROW_Z:  prdata = cfg_q.row_z;
      vtbr_pkg::REG_CENTER: prdata = vtbr_pkg::CFG_DATA_W'(cfg_q.center);
      default:              prdata = '0;
    endcase
  end

  // transform and squared distance
  vtbr_xform #(
    .COORD_WIDTH(W)
  ) u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .vx_i    (s_axis_tdata[W-1:0]),
    .vy_i    (s_axis_tdata[2*W-1:W]),
    .vz_i    (s_axis_tdata[3*W-1:2*W]),
    .valid_o (c_vld[0]),
    .ready_i (c_rdy[0]),
    .root_o  (c_dat[0]),
    .coord_o (c_pay[0])
  );

  // square root chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    vtbr_root_cell #(
      .STEP(i),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_vld[i]),
      .ready_o (c_rdy[i]),
      .root_i  (c_dat[i]),
      .pay_i   (c_pay[i]),
      .valid_o (c_vld[i+1]),
      .ready_i (c_rdy[i+1]),
      .root_o  (c_dat[i+1]),
      .pay_o   (c_pay[i+1])
    );
  end

  assign c_rdy[NCELL] = out_rdy;

  // running maximum and output register
  vtbr_out #(
    .PW(PW)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c_vld[NCELL]),
    .ready_o  (out_rdy),
    .root_i   (c_dat[NCELL]),
    .pay_i    (c_pay[NCELL]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .pay_o    (out_pay),
    .radius_o (out_rad)
  );

  assign m_axis_tdata = ODW'({out_rad, out_pay});

endmodule

// ===== test/vertex_transform_bounding_radius_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_bounding_radius_tb: self-checking bench for the transform
// Streams q8.8 vertices through the block under several matrix and center
// settings, predicts each transformed vertex and the running radius, and
// compares every result word field by field with random stalls on both sides.
// ----------------------------------------------------------------------------
module vertex_transform_bounding_radius_tb;

  localparam int unsigned CW       = vtbr_pkg::COORD_WIDTH_DEF;
  localparam int unsigned RW       = vtbr_pkg::RADIUS_W;
  localparam int unsigned IN_W     = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((3 * CW + RW + 7) / 8) * 8;
  localparam int unsigned LATENCY  = 40;
  localparam int unsigned SETTLE   = LATENCY + 8;
  localparam int unsigned WD_LIMIT = 2000;
  localparam int unsigned HOLD_LEN = 240;
  localparam int unsigned SEG_ITEMS = 64;

  typedef struct {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [RW-1:0] radius;
  } vertex_result_t;

  logic clk_i;
  logic rst_ni;

  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // fields from bit 0: vertex_x, vertex_y, vertex_z
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // fields from bit 0: out_x, out_y, out_z, radius
  logic [OUT_W-1:0] m_axis_tdata;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [vtbr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [vtbr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [vtbr_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // local copy of the block configuration and running radius
  logic [63:0]                   row_x_cfg;
  logic [63:0]                   row_y_cfg;
  logic [63:0]                   row_z_cfg;
  logic [vtbr_pkg::CENTER_W-1:0] center_cfg;
  logic [RW-1:0]                 peak_radius;

  logic [IN_W-1:0] vertex_backlog[$];
  vertex_result_t  pending_results[$];

  int src_idle_pct;
  int sink_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_cnt;
  int fault_count;
  int stall_cycles;

  vertex_transform_bounding_radius #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic longint coeff_lane(logic [63:0] r, int k);
    logic signed [vtbr_pkg::LANE_W-1:0] v;
    v = r[vtbr_pkg::LANE_W*k +: vtbr_pkg::LANE_W];
    return longint'(v);
  endfunction

  // one matrix row: exact q16.16 sum, floored to q8.8, saturated
  function automatic longint row_value(logic [63:0] row, longint x, longint y, longint z);
    longint acc;
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (CW - 1)) - 1;
    lo  = -hi - 1;
    acc = coeff_lane(row, 0) * x + coeff_lane(row, 1) * y + coeff_lane(row, 2) * z
        + coeff_lane(row, 3) * 256;
    acc = acc >>> 8;
    if (acc > hi) acc = hi;
    else if (acc < lo) acc = lo;
    return acc;
  endfunction

  // truncating square root, two bits of radicand per step
  function automatic longint unsigned trunc_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'h1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_of(longint d);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  // transformed vertex and the running radius that includes it
  function automatic vertex_result_t transform_vertex(logic [IN_W-1:0] word);
    vertex_result_t  r;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    longint          tx;
    longint          ty;
    longint          tz;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned dz;
    longint unsigned lim;
    longint unsigned dist_val;
    sx = word[0 +: CW];
    sy = word[CW +: CW];
    sz = word[2*CW +: CW];
    tx = row_value(row_x_cfg, longint'(sx), longint'(sy), longint'(sz));
    ty = row_value(row_y_cfg, longint'(sx), longint'(sy), longint'(sz));
    tz = row_value(row_z_cfg, longint'(sx), longint'(sy), longint'(sz));
    dx = mag_of(tx - coeff_lane(64'(center_cfg), 0));
    dy = mag_of(ty - coeff_lane(64'(center_cfg), 1));
    dz = mag_of(tz - coeff_lane(64'(center_cfg), 2));
    lim = 64'h1 << vtbr_pkg::MAG_W;
    if (dx >= lim || dy >= lim || dz >= lim) begin
      dist_val = vtbr_pkg::RADIUS_MAX;
    end else begin
      dist_val = trunc_sqrt(dx * dx + dy * dy + dz * dz);
      if (dist_val > vtbr_pkg::RADIUS_MAX) dist_val = vtbr_pkg::RADIUS_MAX;
    end
    if (dist_val > peak_radius) peak_radius = dist_val[RW-1:0];
    r.px     = tx[CW-1:0];
    r.py     = ty[CW-1:0];
    r.pz     = tz[CW-1:0];
    r.radius = peak_radius;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // vertex driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(transform_vertex(s_axis_tdata));
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (vertex_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tdata  <= vertex_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    vertex_result_t want;
    logic [CW-1:0] got_x;
    logic [CW-1:0] got_y;
    logic [CW-1:0] got_z;
    logic [RW-1:0] got_r;
    got_x = m_axis_tdata[0 +: CW];
    got_y = m_axis_tdata[CW +: CW];
    got_z = m_axis_tdata[2*CW +: CW];
    got_r = m_axis_tdata[3*CW +: RW];
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result word: x=%h y=%h z=%h radius=%h",
                   got_x, got_y, got_z, got_r);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (got_x !== want.px || got_y !== want.py || got_z !== want.pz ||
            got_r !== want.radius) begin
          if (fault_count < 10)
            $display("mismatch: exp x=%h y=%h z=%h r=%h, got x=%h y=%h z=%h r=%h",
                     want.px, want.py, want.pz, want.radius,
                     got_x, got_y, got_z, got_r);
          fault_count++;
        end
      end
    end
    // long hold-off requested once, otherwise random stalls
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog: cycles without any accepted word or register access
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input vtbr_pkg::reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      vtbr_pkg::REG_ROW_X:  row_x_cfg  = value;
      vtbr_pkg::REG_ROW_Y:  row_y_cfg  = value;
      vtbr_pkg::REG_ROW_Z:  row_z_cfg  = value;
      vtbr_pkg::REG_CENTER: center_cfg = value[vtbr_pkg::CENTER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [63:0] rx, input logic [63:0] ry,
                              input logic [63:0] rz, input logic [63:0] ctr);
    write_reg(vtbr_pkg::REG_ROW_X, rx);
    write_reg(vtbr_pkg::REG_ROW_Y, ry);
    write_reg(vtbr_pkg::REG_ROW_Z, rz);
    write_reg(vtbr_pkg::REG_CENTER, ctr);
  endtask

  // sender pauses until every result is back and the pipe is empty
  task automatic drain();
    do @(negedge clk_i);
    while (vertex_backlog.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    int sel;
    int v;
    sel = $urandom_range(9);
    if (sel < 6) return CW'($urandom);
    if (sel < 8) begin
      v = $urandom_range(2048) - 1024;
      return CW'(v);
    end
    case ($urandom_range(4))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return CW'(1);
    endcase
  endfunction

  // coefficients within +-2.0 so most results stay unsaturated
  function automatic logic [63:0] small_row();
    logic [63:0] r;
    int v;
    for (int k = 0; k < 4; k++) begin
      v = $urandom_range(1024) - 512;
      r[16*k +: 16] = 16'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [IN_W-1:0] corner[11];
    logic [63:0] rx;
    logic [63:0] ry;
    logic [63:0] rz;
    logic [63:0] ctr;

    // corner vertices, {z, y, x}
    corner[0]  = {16'h0000, 16'h0000, 16'h0000};
    corner[1]  = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    corner[2]  = {16'h8000, 16'h8000, 16'h8000};
    corner[3]  = {16'h8000, 16'h0001, 16'hFFFF};
    corner[4]  = {16'h7FFF, 16'hFFFF, 16'h0001};
    corner[5]  = {16'h0000, 16'h8000, 16'h7FFF};
    corner[6]  = {16'h00FF, 16'hAAAA, 16'h5555};
    corner[7]  = {16'h0000, 16'h0000, 16'hFFFF};
    corner[8]  = {16'h0000, 16'hFFFF, 16'h0000};
    corner[9]  = {16'h0000, 16'h0000, 16'h0001};
    corner[10] = {16'h0100, 16'h0100, 16'h0100};

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_idle_pct  = 6;
    sink_idle_pct = 76;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    hold_cnt      = 0;
    fault_count   = 0;
    stall_cycles  = 0;
    row_x_cfg     = vtbr_pkg::ROW_X_RST;
    row_y_cfg     = vtbr_pkg::ROW_Y_RST;
    row_z_cfg     = vtbr_pkg::ROW_Z_RST;
    center_cfg    = vtbr_pkg::CENTER_RST;
    peak_radius   = '0;

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity rows from reset: corners pass straight through
    for (int i = 0; i < 7; i++) vertex_backlog.push_back(corner[i]);
    drain();

    // extreme rows, fractional z row for flooring, center at the corners;
    // junk above the center width must be ignored
    load_setting(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                 64'h0000_0180_0080_FF80, 64'hFFFF_8000_7FFF_8000);
    for (int i = 0; i < 11; i++) vertex_backlog.push_back(corner[i]);
    drain();

    // random segments: sender light / receiver heavy, then reversed, then none
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0, 2: begin
          rx = {$urandom, $urandom};
          ry = {$urandom, $urandom};
          rz = {$urandom, $urandom};
        end
        5: begin
          rx = '1;
          ry = '1;
          rz = '1;
        end
        default: begin
          rx = small_row();
          ry = small_row();
          rz = small_row();
        end
      endcase
      ctr = (seg == 5) ? 64'h0 : {$urandom, $urandom};
      load_setting(rx, ry, rz, ctr);
      src_idle_pct  = (seg < 2) ? 6 : (seg < 4) ? 76 : 0;
      sink_idle_pct = (seg < 2) ? 76 : (seg < 4) ? 6 : 0;
      for (int i = 0; i < SEG_ITEMS; i++)
        vertex_backlog.push_back({rand_coord(), rand_coord(), rand_coord()});
      // receiver backs off while the sender keeps offering
      if (seg == 4) hold_req = 1'b1;
      drain();
    end

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
